FILE: hw/rtl/bapr_pkg.sv
// shared types, constants and helper functions for the bitmap attribute renderer
// no dependencies
package bapr_pkg;

	localparam int unsigned SHADOW_DEPTH = 6912;
	localparam int unsigned OFF_W        = 13;

	localparam logic [15:0] VIDEO_BASE = 16'h4000;
	localparam logic [15:0] VIDEO_END  = 16'h5B00;

	localparam logic [OFF_W-1:0] CLEAR_LAST = OFF_W'(SHADOW_DEPTH - 1);

	localparam logic [2:0] LAST_GROUP = 3'd7;

	// one command for the render back end
	typedef struct packed {
		logic             is_attr;
		logic [OFF_W-1:0] off;
		logic [7:0]       data;
		logic             flash;
	} cmd_t;

	// screen row of a bitmap offset (thirds, pixel line and character row interleave)
	function automatic logic [7:0] row_of(input logic [OFF_W-1:0] off);
		logic [7:0] s;
		s = off[12:5];
		return {s[7:6], s[2:0], s[5:3]};
	endfunction

	// shadow index of the attribute covering a bitmap offset
	function automatic logic [OFF_W-1:0] attr_index(input logic [OFF_W-1:0] off);
		logic [7:0] y;
		y = row_of(off);
		return {2'b11, 1'b0, y[7:3], off[4:0]};
	endfunction

	// bitmap offset of the top row of the cell owning an attribute offset
	function automatic logic [OFF_W-1:0] cell_top(input logic [OFF_W-1:0] off);
		return {off[9:8], 3'b000, off[7:5], off[4:0]};
	endfunction

	function automatic logic [5:0] colour_of(input logic r, input logic g, input logic b,
	                                         input logic bright);
		logic [1:0] lvl;
		lvl = bright ? 2'b11 : 2'b01;
		return {(b ? lvl : 2'b00), (g ? lvl : 2'b00), (r ? lvl : 2'b00)};
	endfunction

endpackage

FILE: hw/rtl/bapr_front.sv
// front end: takes input beats, tracks the flash phase, drops out-of-range writes
// depends on bapr_pkg
module bapr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              mode,
	input  logic [15:0]       address,
	input  logic [7:0]        data,
	input  logic              q_full,
	input  logic              clr_busy,
	output logic              push,
	output bapr_pkg::cmd_t    push_cmd
);

	logic             flash_q;
	logic             take;
	logic             in_range;
	logic [15:0]      rel_addr;

	assign in_ready = !clr_busy && !q_full;
	assign take     = in_valid && in_ready;
	assign in_range = (address >= bapr_pkg::VIDEO_BASE) && (address < bapr_pkg::VIDEO_END);
	assign rel_addr = address - bapr_pkg::VIDEO_BASE;

	assign push = take && !mode && in_range;

	always_comb begin
		push_cmd.off     = rel_addr[bapr_pkg::OFF_W-1:0];
		push_cmd.is_attr = (rel_addr[12:11] == 2'b11);
		push_cmd.data    = data;
		push_cmd.flash   = flash_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flash_q <= 1'b0;
		end else if (take && mode) begin
			flash_q <= !flash_q;
		end
	end

endmodule

FILE: hw/rtl/bapr_queue.sv
// small command queue between the front and back ends
// depends on bapr_pkg
module bapr_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  bapr_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output bapr_pkg::cmd_t pop_cmd,
	output logic           empty
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	bapr_pkg::cmd_t   slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_FULL);
	assign empty   = (count_q == '0);
	assign pop_cmd = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: hw/rtl/bapr_back.sv
// back end: owns the video shadow memory, stores writes and renders pixel groups
// depends on bapr_pkg
module bapr_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  bapr_pkg::cmd_t    q_cmd,
	output logic              q_pop,
	output logic              clr_busy,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        out_x,
	output logic [7:0]        out_y,
	output logic [47:0]       out_colors,
	output logic              out_last
);

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_OUT   = 3'b100
	} state_t;

	localparam int unsigned OW = bapr_pkg::OFF_W;

	logic [7:0]    mem [bapr_pkg::SHADOW_DEPTH];

	state_t        state_q;
	logic [OW-1:0] clr_cnt_q;
	logic [7:0]    rd_q;
	logic          is_attr_q;
	logic [7:0]    data_q;
	logic          flash_q;
	logic [OW-1:0] cur_off_q;
	logic [2:0]    grp_q;

	logic          out_valid_q;
	logic [7:0]    out_x_q;
	logic [7:0]    out_y_q;
	logic [47:0]   out_colors_q;
	logic          out_last_q;

	logic          mem_we;
	logic [OW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic          rd_en;
	logic [OW-1:0] rd_addr;
	logic          load;
	logic          grp_last;
	logic [2:0]    grp_next;
	logic [OW-1:0] next_off;
	logic [OW-1:0] first_off;

	logic [7:0]    y;
	logic [7:0]    attr;
	logic [7:0]    bits;
	logic [5:0]    ink;
	logic [5:0]    paper;
	logic          invert;
	logic [47:0]   colors;

	assign clr_busy  = (state_q == ST_CLEAR);
	assign load      = (state_q == ST_OUT) && (!out_valid_q || out_ready);
	assign grp_last  = !is_attr_q || (grp_q == bapr_pkg::LAST_GROUP);
	assign grp_next  = grp_q + 3'd1;
	assign next_off  = {cur_off_q[12:11], grp_next, cur_off_q[7:0]};
	assign first_off = q_cmd.is_attr ? bapr_pkg::cell_top(q_cmd.off) : q_cmd.off;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_cnt_q;
		mem_wdata = '0;
		rd_en     = 1'b0;
		rd_addr   = next_off;
		q_pop     = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_IDLE: begin
				if (!q_empty) begin
					q_pop     = 1'b1;
					mem_we    = 1'b1;
					mem_waddr = q_cmd.off;
					mem_wdata = q_cmd.data;
					rd_en     = 1'b1;
					// bitmap write needs its attribute, attribute write its top bitmap row
					rd_addr   = q_cmd.is_attr ? first_off : bapr_pkg::attr_index(q_cmd.off);
				end
			end
			ST_OUT: begin
				rd_en = load && !grp_last;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// render the current group from the command byte and the byte read back
	always_comb begin
		y      = bapr_pkg::row_of(cur_off_q);
		attr   = is_attr_q ? data_q : rd_q;
		bits   = is_attr_q ? rd_q : data_q;
		ink    = bapr_pkg::colour_of(attr[1], attr[2], attr[0], attr[6]);
		paper  = bapr_pkg::colour_of(attr[4], attr[5], attr[3], attr[6]);
		invert = flash_q && attr[7];
		for (int i = 0; i < 8; i++) begin
			colors[i*6 +: 6] = (bits[7-i] ^ invert) ? ink : paper;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			grp_q     <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == bapr_pkg::CLEAR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (!q_empty) begin
						grp_q   <= '0;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (load) begin
						if (grp_last) begin
							state_q <= ST_IDLE;
						end else begin
							grp_q <= grp_next;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			is_attr_q <= q_cmd.is_attr;
			data_q    <= q_cmd.data;
			flash_q   <= q_cmd.flash;
			cur_off_q <= first_off;
		end else if (load && !grp_last) begin
			cur_off_q <= next_off;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_x_q      <= {cur_off_q[4:0], 3'b000};
			out_y_q      <= y;
			out_colors_q <= colors;
			out_last_q   <= grp_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_x      = out_x_q;
	assign out_y      = out_y_q;
	assign out_colors = out_colors_q;
	assign out_last   = out_last_q;

endmodule

FILE: hw/rtl/bitmap_attribute_pixel_renderer.sv
// bitmap attribute pixel renderer: a write passes the command queue, the shadow read
// and the output register before its first pixel group; a bitmap write gives 1 group, an
// attribute write gives 8 groups, one a cycle while m_axis_tready is high; the next
// queued write starts after the last group; after reset a clearing pass writes zero to
// all 6912 shadow bytes, s_axis_tready stays low meanwhile; flash phase resets to off
module bitmap_attribute_pixel_renderer #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // address[15:0], data[23:16]
	input  logic        s_axis_tuser,  // mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // pixel_x, pixel_y, color_0 .. color_7 (6 bits each)
	output logic        m_axis_tlast
);

	logic           q_full;
	logic           q_empty;
	logic           q_push;
	logic           q_pop;
	logic           clr_busy;
	bapr_pkg::cmd_t push_cmd;
	bapr_pkg::cmd_t pop_cmd;
	logic [7:0]     out_x;
	logic [7:0]     out_y;
	logic [47:0]    out_colors;

	bapr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.mode     (s_axis_tuser),
		.address  (s_axis_tdata[15:0]),
		.data     (s_axis_tdata[23:16]),
		.q_full   (q_full),
		.clr_busy (clr_busy),
		.push     (q_push),
		.push_cmd (push_cmd)
	);

	bapr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.pop_cmd  (pop_cmd),
		.empty    (q_empty)
	);

	bapr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_cmd      (pop_cmd),
		.q_pop      (q_pop),
		.clr_busy   (clr_busy),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_x      (out_x),
		.out_y      (out_y),
		.out_colors (out_colors),
		.out_last   (m_axis_tlast)
	);

	assign m_axis_tdata = {out_colors, out_y, out_x};

endmodule

FILE: verif/bitmap_attribute_pixel_renderer_tb.sv
`timescale 1ns / 1ps
// testbench for bitmap_attribute_pixel_renderer: directed and random cpu video writes and
// flash toggles, each pixel group checked against a local screen-memory predictor
// needs bapr_pkg and the rtl
module bitmap_attribute_pixel_renderer_tb;

	localparam int WRITE_TARGET = 390;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int DRAIN_TAIL   = 20;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_FLASH = 1'b1;

	localparam logic [15:0] ATTR_START = 16'h5800;
	localparam logic [12:0] ATTR_OFF   = 13'd6144;

	typedef struct {
		logic        mode;
		logic [15:0] address;
		logic [7:0]  data;
		logic        drain;
	} cpu_write_t;

	typedef struct packed {
		logic [7:0]      x;
		logic [7:0]      y;
		logic [7:0][5:0] colour;
		logic            last;
	} pixel_group_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;
	logic        m_axis_tlast;

	logic [7:0]   screen_mem [bapr_pkg::SHADOW_DEPTH];
	logic         flash_on;
	pixel_group_t expected_groups [$];
	cpu_write_t   pending_writes [$];
	cpu_write_t   on_bus;
	bit           beat_taken = 1'b0;
	int           total_writes = 0;
	int           issued_count = 0;
	int           accepted_count = 0;
	int           phase_len = 1;
	int           tx_idle_pct = 21;
	int           rx_idle_pct = 85;
	int           error_count = 0;
	int           cycle_count = 0;

	bitmap_attribute_pixel_renderer uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #5 clk = ~clk;

	function automatic void queue_write(logic mode, logic [15:0] address, logic [7:0] data,
	                                    logic drain);
		cpu_write_t w;
		w.mode    = mode;
		w.address = address;
		w.data    = data;
		w.drain   = drain;
		pending_writes.push_back(w);
	endfunction

	// 2-bit level per lit component, order red, green, blue from the low bits
	function automatic logic [5:0] rgb_level(logic r, logic g, logic b, logic bright);
		logic [1:0] on_lvl;
		on_lvl = bright ? 2'b11 : 2'b01;
		return {b ? on_lvl : 2'b00, g ? on_lvl : 2'b00, r ? on_lvl : 2'b00};
	endfunction

	function automatic logic [15:0] cell_row_addr(int cy, int cx, int r);
		logic [4:0] ycell;
		logic [4:0] xcell;
		logic [2:0] line;
		ycell = 5'(cy);
		xcell = 5'(cx);
		line  = 3'(r);
		return bapr_pkg::VIDEO_BASE + {3'b000, ycell[4:3], line, ycell[2:0], xcell};
	endfunction

	task automatic expect_group(logic [12:0] off, logic last);
		logic [7:0]   s;
		logic [7:0]   y;
		logic [7:0]   attr;
		logic [7:0]   bits;
		logic [5:0]   ink;
		logic [5:0]   paper;
		logic         swap;
		pixel_group_t g;
		s     = off[12:5];
		y     = {s[7:6], s[2:0], s[5:3]};
		attr  = screen_mem[13'(int'(ATTR_OFF) + int'(y[7:3]) * 32 + int'(off[4:0]))];
		bits  = screen_mem[off];
		ink   = rgb_level(attr[1], attr[2], attr[0], attr[6]);
		paper = rgb_level(attr[4], attr[5], attr[3], attr[6]);
		swap  = flash_on & attr[7];
		g.x   = {off[4:0], 3'b000};
		g.y   = y;
		for (int i = 0; i < 8; i++)
			g.colour[i] = (bits[7-i] ^ swap) ? ink : paper;
		g.last = last;
		expected_groups.push_back(g);
	endtask

	task automatic predict_screen_write(cpu_write_t w);
		logic [12:0] off;
		logic [12:0] top;
		logic [7:0]  row;
		if (w.mode == MODE_FLASH) begin
			flash_on = ~flash_on;
		end else if (w.address >= bapr_pkg::VIDEO_BASE && w.address < bapr_pkg::VIDEO_END) begin
			off = 13'(w.address - bapr_pkg::VIDEO_BASE);
			screen_mem[off] = w.data;
			if (w.address < ATTR_START) begin
				expect_group(off, 1'b1);
			end else begin
				// attribute: redraw all 8 lines of the cell, lines are 0x100 apart
				row = 8'(((off - ATTR_OFF) >> 5) * 8);
				top = {row[7:6], 3'b000, row[5:3], off[4:0]};
				for (int k = 0; k < 8; k++) begin
					expect_group(top, k == 7);
					top = top + 13'h100;
				end
			end
		end
	endtask

	// stimulus side, new beat at the falling edge
	always @(negedge clk) begin : drive_writes
		cpu_write_t w;
		if (arst_n && !(s_axis_tvalid && !beat_taken)) begin
			beat_taken = 1'b0;
			if (pending_writes.size() > 0
			    && (!pending_writes[0].drain || expected_groups.size() == 0)
			    && $urandom_range(99) >= tx_idle_pct) begin
				w = pending_writes.pop_front();
				on_bus = w;
				issued_count++;
				if (issued_count >= 2 * phase_len) begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end else if (issued_count >= phase_len) begin
					tx_idle_pct = 85;
					rx_idle_pct = 21;
				end
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= {w.data, w.address};
				s_axis_tuser  <= w.mode;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : drive_ready
		m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin : watch_beats
		pixel_group_t want;
		logic         bad;
		if (arst_n) begin
			cycle_count++;
			if (s_axis_tvalid && s_axis_tready) begin
				predict_screen_write(on_bus);
				accepted_count++;
				beat_taken = 1'b1;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_groups.size() == 0) begin
					error_count++;
					if (error_count <= 10)
						$display("unexpected pixel group: x=%0d y=%0d colours=%h last=%b",
						         m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[63:16],
						         m_axis_tlast);
				end else begin
					want = expected_groups.pop_front();
					bad  = (m_axis_tdata[7:0] != want.x) || (m_axis_tdata[15:8] != want.y)
					       || (m_axis_tlast != want.last);
					for (int i = 0; i < 8; i++)
						bad |= (m_axis_tdata[16 + 6*i +: 6] != want.colour[i]);
					if (bad) begin
						error_count++;
						if (error_count <= 10) begin
							$write("pixel group mismatch: expected x=%0d y=%0d colours=%h last=%b, ",
							       want.x, want.y, want.colour, want.last);
							$display("got x=%0d y=%0d colours=%h last=%b",
							         m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[63:16],
							         m_axis_tlast);
						end
					end
				end
			end
			if (cycle_count > CYCLE_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin : run_test
		int         screen_writes;
		int         pick;
		int         cy;
		int         cx;
		int         first_line;
		logic [15:0] addr;
		for (int i = 0; i < bapr_pkg::SHADOW_DEPTH; i++)
			screen_mem[i] = 8'h00;
		flash_on = 1'b0;

		// directed: corners of bitmap and attribute areas, flash, out-of-range addresses
		queue_write(MODE_WRITE, 16'h4000, 8'hFF, 1'b0);
		queue_write(MODE_WRITE, 16'h5800, 8'hFF, 1'b0);
		queue_write(MODE_WRITE, 16'h57FF, 8'hA5, 1'b0);
		queue_write(MODE_WRITE, 16'h5AFF, 8'h47, 1'b0);
		queue_write(MODE_WRITE, 16'h57FF, 8'h00, 1'b0);
		queue_write(MODE_FLASH, 16'hFFFF, 8'hFF, 1'b0);
		queue_write(MODE_WRITE, 16'h5800, 8'hB8, 1'b0);
		queue_write(MODE_WRITE, 16'h4000, 8'h0F, 1'b0);
		queue_write(MODE_WRITE, 16'h3FFF, 8'h55, 1'b0);
		queue_write(MODE_WRITE, 16'h5B00, 8'hAA, 1'b0);
		queue_write(MODE_WRITE, 16'h0000, 8'hFF, 1'b0);
		queue_write(MODE_WRITE, 16'hFFFF, 8'h81, 1'b0);
		queue_write(MODE_FLASH, 16'h4000, 8'h12, 1'b0);
		queue_write(MODE_WRITE, 16'h4100, 8'h81, 1'b0);
		queue_write(MODE_WRITE, 16'h5A1F, 8'h3F, 1'b0);
		queue_write(MODE_WRITE, 16'h4FE0, 8'h3C, 1'b0);
		queue_write(MODE_WRITE, 16'h5000, 8'hC3, 1'b0);
		queue_write(MODE_WRITE, 16'h5900, 8'h7A, 1'b0);
		queue_write(MODE_FLASH, 16'h0000, 8'h00, 1'b0);
		queue_write(MODE_WRITE, 16'h5900, 8'hC0, 1'b1);

		// random: mostly whole cells (attribute plus its lines), plus loose writes and noise
		screen_writes = 0;
		while (screen_writes < WRITE_TARGET) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				queue_write(MODE_FLASH, 16'($urandom), 8'($urandom), 1'b0);
			end else if (pick < 16) begin
				addr = $urandom_range(1) ? 16'($urandom_range(16'h3FFF))
				                         : 16'($urandom_range(16'hFFFF, 16'h5B00));
				queue_write(MODE_WRITE, addr, 8'($urandom), 1'b0);
			end else if (pick < 40) begin
				cy = $urandom_range(23);
				cx = $urandom_range(31);
				first_line = $urandom_range(1);
				if (first_line == 0)
					queue_write(MODE_WRITE, 16'(ATTR_START + cy * 32 + cx), 8'($urandom),
					            screen_writes % 70 == 0);
				for (int r = 0; r < 8; r++)
					queue_write(MODE_WRITE, cell_row_addr(cy, cx, r), 8'($urandom), 1'b0);
				if (first_line != 0)
					queue_write(MODE_WRITE, 16'(ATTR_START + cy * 32 + cx), 8'($urandom),
					            1'b0);
				screen_writes += 9;
			end else if (pick < 70) begin
				queue_write(MODE_WRITE, 16'($urandom_range(16'h57FF, 16'h4000)), 8'($urandom),
				            screen_writes % 70 == 0);
				screen_writes++;
			end else begin
				queue_write(MODE_WRITE, 16'($urandom_range(16'h5AFF, 16'h5800)), 8'($urandom),
				            1'b0);
				screen_writes++;
			end
		end
		total_writes = pending_writes.size();
		phase_len    = total_writes / 3;
		// hold off at each idling change until the block has drained
		pending_writes[phase_len].drain     = 1'b1;
		pending_writes[2 * phase_len].drain = 1'b1;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (!(accepted_count == total_writes && expected_groups.size() == 0))
			@(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
		if (error_count == 0 && expected_groups.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
